### rtl/ifd_pkg.sv
// Shared types and constants for the image frame deframer.
// Holds beat structs, status codes and header markers; no dependencies.
`default_nettype none

package ifd_pkg;

    // Header markers
    localparam logic [7:0] MARK_FIRST  = 8'h4D;   // 'M'
    localparam logic [7:0] MARK_SECOND = 8'h4E;   // 'N'

    // Input operation codes
    typedef enum logic {
        OP_RX_BYTE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_NONE  = 3'd0,
        ST_PIXEL = 3'd1,
        ST_OK    = 3'd2,
        ST_WERR  = 3'd3,
        ST_HERR  = 3'd4,
        ST_CERR  = 3'd5,
        ST_BUSY  = 3'd6
    } status_t;

    // Register indexes on the APB port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [7:0] WIDTH_RESET  = 8'd28;
    localparam logic [7:0] HEIGHT_RESET = 8'd28;

    // Wide enough for width*height and for the largest buffer size
    localparam int CMP_W = 17;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] pixel_addr;
        logic [7:0] pixel_value;
        logic       buffer_select;
        logic [1:0] full_buffers;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] width;
        logic [7:0] height;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/ifd_apb_regs.sv
// APB register file for the expected image width and height.
// Depends on ifd_pkg for the register indexes and the config struct.
`default_nettype none

module ifd_apb_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output ifd_pkg::cfg_t      cfg
);

    logic [7:0] width_reg;
    logic [7:0] height_reg;
    logic       wr_en;
    logic       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ifd_pkg::WIDTH_RESET;
            height_reg <= ifd_pkg::HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            if (reg_idx == ifd_pkg::REG_WIDTH)
                width_reg <= pwdata[7:0];
            else
                height_reg <= pwdata[7:0];
        end
    end

    // Read mux
    always_comb
    begin
        if (reg_idx == ifd_pkg::REG_WIDTH)
            prdata = {24'd0, width_reg};
        else
            prdata = {24'd0, height_reg};
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

endmodule

`default_nettype wire

### rtl/ifd_engine.sv
// Frame parser state and per-byte result logic of the deframer.
// Depends on ifd_pkg; state advances on each step from the top level.
`default_nettype none

module ifd_engine #(
    parameter int MAX_IMAGE_BYTES = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire ifd_pkg::in_beat_t  beat,
    input  wire ifd_pkg::cfg_t      cfg,
    output ifd_pkg::out_beat_t      result
);

    localparam int POS_W = $clog2(MAX_IMAGE_BYTES + 1);
    localparam logic [ifd_pkg::CMP_W-1:0] MAX_BYTES = ifd_pkg::CMP_W'(MAX_IMAGE_BYTES);

    typedef enum logic [5:0] {
        PH_MARK1  = 6'b000001,
        PH_MARK2  = 6'b000010,
        PH_WIDTH  = 6'b000100,
        PH_HEIGHT = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_CHECK  = 6'b100000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]         xor_reg, xor_next;
    logic               wbuf_reg, wbuf_next;
    logic [1:0]         fill_reg, fill_next;

    logic [15:0]                img_bytes;
    logic [ifd_pkg::CMP_W-1:0]  img_wide;
    logic [ifd_pkg::CMP_W-1:0]  pos_wide;
    logic [ifd_pkg::CMP_W-1:0]  pos_inc_wide;
    logic [POS_W-1:0]           pos_inc;

    // Image size from the current registers
    assign img_bytes    = 16'(cfg.width) * 16'(cfg.height);
    assign img_wide     = ifd_pkg::CMP_W'(img_bytes);
    assign pos_inc      = pos_reg + POS_W'(1);
    assign pos_wide     = ifd_pkg::CMP_W'(pos_reg);
    assign pos_inc_wide = ifd_pkg::CMP_W'(pos_inc);

    // Per-byte decode and next state
    always_comb
    begin
        phase_next           = phase_reg;
        pos_next             = pos_reg;
        xor_next             = xor_reg;
        wbuf_next            = wbuf_reg;
        fill_next            = fill_reg;
        result.status        = ifd_pkg::ST_NONE;
        result.pixel_addr    = 10'd0;
        result.pixel_value   = 8'd0;
        result.buffer_select = wbuf_reg;

        if (beat.op == ifd_pkg::OP_RELEASE)
        begin
            if (fill_reg != 2'd0)
            begin
                result.buffer_select = (fill_reg == 2'd1) ? ~wbuf_reg : wbuf_reg;
                fill_next            = fill_reg - 2'd1;
            end
        end
        else if (fill_reg >= 2'd2)
        begin
            result.status = ifd_pkg::ST_BUSY;
        end
        else
        begin
            case (phase_reg)
                PH_MARK1:
                begin
                    if (beat.rx_byte == ifd_pkg::MARK_FIRST)
                        phase_next = PH_MARK2;
                end
                PH_MARK2:
                begin
                    phase_next = (beat.rx_byte == ifd_pkg::MARK_SECOND) ? PH_WIDTH : PH_MARK1;
                end
                PH_WIDTH:
                begin
                    if (beat.rx_byte == cfg.width)
                        phase_next = PH_HEIGHT;
                    else
                    begin
                        result.status = ifd_pkg::ST_WERR;
                        phase_next    = PH_MARK1;
                    end
                end
                PH_HEIGHT:
                begin
                    if (beat.rx_byte == cfg.height && img_wide <= MAX_BYTES)
                    begin
                        pos_next   = '0;
                        xor_next   = 8'd0;
                        phase_next = (img_bytes == 16'd0) ? PH_CHECK : PH_DATA;
                    end
                    else
                    begin
                        result.status = ifd_pkg::ST_HERR;
                        phase_next    = PH_MARK1;
                    end
                end
                PH_DATA:
                begin
                    result.status      = ifd_pkg::ST_PIXEL;
                    result.pixel_addr  = pos_wide[9:0];
                    result.pixel_value = beat.rx_byte;
                    xor_next           = xor_reg ^ beat.rx_byte;
                    pos_next           = pos_inc;
                    if (pos_inc_wide >= img_wide || pos_inc_wide >= MAX_BYTES)
                        phase_next = PH_CHECK;
                end
                PH_CHECK:
                begin
                    if (beat.rx_byte == xor_reg)
                    begin
                        result.status = ifd_pkg::ST_OK;
                        fill_next     = fill_reg + 2'd1;
                        wbuf_next     = ~wbuf_reg;
                    end
                    else
                        result.status = ifd_pkg::ST_CERR;
                    phase_next = PH_MARK1;
                end
                default:
                begin
                    phase_next = PH_MARK1;
                end
            endcase
        end

        result.full_buffers = fill_next;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MARK1;
            pos_reg   <= '0;
            xor_reg   <= 8'd0;
            wbuf_reg  <= 1'b0;
            fill_reg  <= 2'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            wbuf_reg  <= wbuf_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

`default_nettype wire

### rtl/image_frame_deframer.sv
// Image frame deframer: gives one result beat for each byte or release beat it takes,
// passing through the input register and then the result register. Throughput is one
// beat per clock while the result channel is not stalled. The only per-byte loop is the
// parser state update, through an 8x8 size multiply and a compare. A full
// result register does not block intake while the input register is free. Frames are
// 'M','N', width, height, width*height payload bytes and an XOR checksum byte.
// Depends on ifd_pkg, ifd_apb_regs and ifd_engine.
`default_nettype none

module image_frame_deframer #(
    parameter int MAX_IMAGE_BYTES = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // configuration
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    // byte channel
    input  wire logic          byte_valid,
    output logic               byte_stall,
    input  wire ifd_pkg::in_beat_t byte_beat,
    // result channel
    output logic               result_valid,
    input  wire logic          result_stall,
    output ifd_pkg::out_beat_t result_beat
);

    ifd_pkg::cfg_t      cfg;
    ifd_pkg::in_beat_t  in_beat_reg;
    logic               in_vld_reg, in_vld_next;
    ifd_pkg::out_beat_t out_beat_reg;
    logic               out_vld_reg, out_vld_next;
    ifd_pkg::out_beat_t eng_result;
    logic               advance;
    logic               take;

    ifd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ifd_engine #(
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .beat   (in_beat_reg),
        .cfg    (cfg),
        .result (eng_result)
    );

    // Handshake: move a beat on when the result register is free or draining
    assign advance    = in_vld_reg && (!out_vld_reg || !result_stall);
    assign byte_stall = in_vld_reg && !advance;
    assign take       = byte_valid && !byte_stall;

    assign in_vld_next  = take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : (result_stall ? out_vld_reg : 1'b0);

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
            in_beat_reg <= byte_beat;
        if (advance)
            out_beat_reg <= eng_result;
    end

    assign result_valid = out_vld_reg;
    assign result_beat  = out_beat_reg;

endmodule

`default_nettype wire
